// File: sv/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// shared types, codes and helpers for the arp cache table
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int AGE_W  = 16;
  localparam int TMO_W  = 16;
  localparam int LFSR_W = 16;
  localparam int SLOT_W = 5;
  localparam int ACT_W  = 2;

  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK   = 2'd2;

  localparam logic [LFSR_W-1:0] LFSR_SEED   = 16'hACE1;
  localparam logic [AGE_W-1:0]  AGE_MAX     = 16'hFFFF;
  localparam logic [TMO_W-1:0]  TMO_DEFAULT = 16'd15;

  typedef struct packed {
    logic              valid;
    logic [AGE_W-1:0]  age;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
  } entry_t;

  // fibonacci lfsr, taps 16,14,13,11, shifting right
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[LFSR_W-1:1]};
  endfunction

endpackage

// File: sv/arpc_mod.sv
// ----------------------------------------------------------------------------
// arpc_mod
// remainder of a 16-bit value by a fixed divisor, reciprocal multiply then subtract
// ----------------------------------------------------------------------------
module arpc_mod #(
  parameter int DIVISOR = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [arpc_pkg::LFSR_W-1:0] value,
  output logic                        done,
  output logic [arpc_pkg::LFSR_W-1:0] rem
);
  import arpc_pkg::*;

  // quotient = (value * RECIP) >> SH, exact for every 16-bit value
  localparam int SH = LFSR_W + $clog2(DIVISOR);
  localparam int MW = LFSR_W + 2;
  localparam int PW = LFSR_W + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic              stage_r, stage_nxt;
  logic              done_r, done_nxt;
  logic [LFSR_W-1:0] val_r, val_nxt;
  logic [PW-1:0]     prod_r, prod_nxt;
  logic [LFSR_W-1:0] rem_r, rem_nxt;
  logic [LFSR_W-1:0] quo;
  logic [LFSR_W-1:0] back;

  assign quo  = LFSR_W'(prod_r >> SH);
  assign back = quo * LFSR_W'(DIVISOR);

  always_comb begin
    stage_nxt = start;
    done_nxt  = stage_r;
    val_nxt   = val_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    if (start) begin
      val_nxt  = value;
      prod_nxt = PW'(value) * PW'(RECIP);
    end
    if (stage_r) begin
      rem_nxt = val_r - back;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
      done_r  <= done_nxt;
    end
    val_r  <= val_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: sv/arp_cache_table_top.sv
// ----------------------------------------------------------------------------
// arp_cache_table_top
// ipv4 to mac cache with lookup, insert with random replacement, and aging
// ----------------------------------------------------------------------------
// scan: a lookup stops at the first hitting entry and an insert at the first free
//   entry, scanned from entry 0; a miss or a tick scans the whole table, an insert
//   into a full table then waits on the remainder, and an unused code skips the scan
// throughput: one item at a time, set by the one-entry-per-cycle scan of the
//   table memory; in_tready is low while an item is in work or waits on out_tready
// reset: a clearing pass over every table entry runs first, in_tready held low
// ----------------------------------------------------------------------------
module arp_cache_table_top #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,    // ip_addr[31:0], new_mac[79:32]
  input  logic [1:0]  in_tuser,    // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // found_mac[47:0], slot[52:48], zero[55:53]
  output logic [0:0]  out_tuser,   // hit[0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import arpc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] CNT_LAST  = CW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_END   = CW'(TABLE_DEPTH);
  localparam logic [AW-1:0] IDX_LAST  = AW'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MOD,
    ST_RESP
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]      chk_idx_r, chk_idx_nxt;
  logic [ACT_W-1:0]   act_r, act_nxt;
  logic [IP_W-1:0]    ip_r, ip_nxt;
  logic [MAC_W-1:0]   mac_r, mac_nxt;
  logic [LFSR_W-1:0]  lfsr_r, lfsr_nxt;
  logic               res_hit_r, res_hit_nxt;
  logic [MAC_W-1:0]   res_mac_r, res_mac_nxt;
  logic [SLOT_W-1:0]  res_slot_r, res_slot_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic [MAC_W-1:0]   out_mac_r, out_mac_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [TMO_W-1:0]   tmo_r;

  entry_t             mem [TABLE_DEPTH];
  entry_t             rdata_r;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  entry_t             mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;

  logic               mod_start;
  logic               mod_done;
  logic [LFSR_W-1:0]  mod_rem;
  logic [AGE_W-1:0]   age_inc;
  logic               chk_last;

  arpc_mod #(
    .DIVISOR (TABLE_DEPTH)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .value (lfsr_nxt),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  assign age_inc  = (rdata_r.age == AGE_MAX) ? AGE_MAX : rdata_r.age + 1'b1;
  assign chk_last = chk_idx_r == IDX_LAST;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    act_nxt        = act_r;
    ip_nxt         = ip_r;
    mac_nxt        = mac_r;
    lfsr_nxt       = lfsr_r;
    res_hit_nxt    = res_hit_r;
    res_mac_nxt    = res_mac_r;
    res_slot_nxt   = res_slot_r;
    out_tvalid_nxt = out_tvalid_r;
    out_hit_nxt    = out_hit_r;
    out_mac_nxt    = out_mac_r;
    out_slot_nxt   = out_slot_r;
    mem_we         = 1'b0;
    mem_waddr      = chk_idx_r;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = cnt_r[AW-1:0];
    mod_start      = 1'b0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_tvalid) begin
          act_nxt      = in_tuser;
          ip_nxt       = in_tdata[IP_W-1:0];
          mac_nxt      = in_tdata[IP_W+MAC_W-1:IP_W];
          res_hit_nxt  = 1'b0;
          res_mac_nxt  = '0;
          res_slot_nxt = '0;
          cnt_nxt      = '0;
          chk_vld_nxt  = 1'b0;
          if (in_tuser == ACT_LOOKUP || in_tuser == ACT_INSERT || in_tuser == ACT_TICK) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end

      ST_SCAN: begin
        // read runs one entry ahead of the check
        mem_re      = cnt_r != CNT_END;
        chk_vld_nxt = mem_re;
        chk_idx_nxt = cnt_r[AW-1:0];
        if (mem_re) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (chk_vld_r) begin
          case (act_r)
            ACT_LOOKUP: begin
              if (rdata_r.valid && rdata_r.ip == ip_r) begin
                res_hit_nxt  = 1'b1;
                res_mac_nxt  = rdata_r.mac;
                res_slot_nxt = SLOT_W'(chk_idx_r);
                state_nxt    = ST_RESP;
              end else if (chk_last) begin
                state_nxt = ST_RESP;
              end
            end
            ACT_INSERT: begin
              if (!rdata_r.valid) begin
                mem_we       = 1'b1;
                mem_wdata    = '{valid: 1'b1, age: '0, ip: ip_r, mac: mac_r};
                res_slot_nxt = SLOT_W'(chk_idx_r);
                state_nxt    = ST_RESP;
              end else if (chk_last) begin
                // table full: pick a victim from the stepped lfsr
                lfsr_nxt  = lfsr_next(lfsr_r);
                mod_start = 1'b1;
                state_nxt = ST_MOD;
              end
            end
            ACT_TICK: begin
              if (rdata_r.valid) begin
                mem_we    = 1'b1;
                mem_wdata = '{valid: age_inc <= tmo_r, age: age_inc,
                              ip: rdata_r.ip, mac: rdata_r.mac};
              end
              if (chk_last) begin
                state_nxt = ST_RESP;
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_MOD: begin
        if (mod_done) begin
          mem_we       = 1'b1;
          mem_waddr    = mod_rem[AW-1:0];
          mem_wdata    = '{valid: 1'b1, age: '0, ip: ip_r, mac: mac_r};
          res_slot_nxt = SLOT_W'(mod_rem[AW-1:0]);
          state_nxt    = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_hit_nxt    = res_hit_r;
          out_mac_nxt    = res_mac_r;
          out_slot_nxt   = res_slot_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cnt_r        <= '0;
      chk_vld_r    <= 1'b0;
      lfsr_r       <= LFSR_SEED;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      chk_vld_r    <= chk_vld_nxt;
      lfsr_r       <= lfsr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    chk_idx_r  <= chk_idx_nxt;
    act_r      <= act_nxt;
    ip_r       <= ip_nxt;
    mac_r      <= mac_nxt;
    res_hit_r  <= res_hit_nxt;
    res_mac_r  <= res_mac_nxt;
    res_slot_r <= res_slot_nxt;
    out_hit_r  <= out_hit_nxt;
    out_mac_r  <= out_mac_nxt;
    out_slot_r <= out_slot_nxt;
  end

  // table memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r <= TMO_DEFAULT;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      tmo_r <= cfg_pwdata[TMO_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {16'd0, tmo_r};

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'd0, out_slot_r, out_mac_r};
  assign out_tuser  = out_hit_r;

endmodule

// File: sv/arpc_chk.sv
// ----------------------------------------------------------------------------
// arpc_chk
// port-level checks for the arp cache table, bound to the top level
// ----------------------------------------------------------------------------
module arpc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // reset starts the clearing pass with nothing offered on either side
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("arpc: ready or valid high right after reset");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("arpc: second beat taken while an item is in work");

  // a result without a hit carries no mac
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[47:0] == 48'd0)
    else $error("arpc: mac present on a result without hit");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("arpc: stalled result beat changed");

endmodule

bind arp_cache_table_top arpc_chk u_arpc_chk (.*);
